// File: design/pvv_pkg.sv
// ----------------------------------------------------------------------------
// pvv_pkg: shared types and codes for the particle integrator
// Operation codes, register indexes, word type and the request that the
// sequencer hands to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package pvv_pkg;

  typedef logic signed [31:0] word_t;

  typedef enum logic [2:0] {
    OP_RST_FORCE   = 3'd0,
    OP_LOAD_FORCE  = 3'd1,
    OP_FIRST_HALF  = 3'd2,
    OP_SECOND_HALF = 3'd3,
    OP_IMPULSE     = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    REG_MASS      = 3'd0,
    REG_INV_MASS  = 3'd1,
    REG_GRAV_X    = 3'd2,
    REG_GRAV_Y    = 3'd3,
    REG_GRAV_Z    = 3'd4,
    REG_TIME_STEP = 3'd5
  } reg_idx_t;

  localparam logic [15:0] TIME_STEP_RESET = 16'd655;

  // result = sat(addend + sat(floor(a * b / 2^(16 or 17))))
  typedef struct packed {
    word_t       a;
    logic [31:0] b;
    logic        half;
    word_t       addend;
  } mac_req_t;

endpackage

// File: design/pvv_mac_unit.sv
// ----------------------------------------------------------------------------
// pvv_mac_unit: shared multiply, shift and saturating add
// Registers the 64-bit product of a signed and an unsigned word, then
// floors it by 16 or 17 bits, saturates and adds the addend with saturation.
// ----------------------------------------------------------------------------
module pvv_mac_unit (
  input  logic              clk,
  input  pvv_pkg::mac_req_t req,
  output pvv_pkg::word_t    res
);
  import pvv_pkg::*;

  logic signed [65:0] prod_full;
  logic signed [63:0] prod_r;
  logic               half_r;
  word_t              addend_r;
  logic signed [63:0] shifted;
  word_t              q_sat;
  logic signed [32:0] sum;

  assign prod_full = $signed({req.a[31], req.a}) * $signed({1'b0, req.b});

  always_ff @(posedge clk) begin
    prod_r   <= prod_full[63:0];
    half_r   <= req.half;
    addend_r <= req.addend;
  end

  always_comb begin
    shifted = half_r ? (prod_r >>> 17) : (prod_r >>> 16);
    if (!shifted[63] && (|shifted[62:31])) begin
      q_sat = 32'sh7fffffff;
    end else if (shifted[63] && !(&shifted[62:31])) begin
      q_sat = 32'sh80000000;
    end else begin
      q_sat = shifted[31:0];
    end
    sum = {q_sat[31], q_sat} + {addend_r[31], addend_r};
    if (sum[32] != sum[31]) begin
      res = sum[32] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      res = sum[31:0];
    end
  end

endmodule

// File: design/particle_velocity_verlet_step.sv
// ----------------------------------------------------------------------------
// particle_velocity_verlet_step: velocity Verlet integrator for one particle
// Holds position, velocity, acceleration, force and half-step velocity and
// runs one operation per request through a shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request: an operation code
//   and a vector. The output channel (out_valid/out_ready) returns position,
//   velocity (half-step velocity after a first half step) and acceleration.
//   The configuration port writes mass, inverse mass, gravity and time step;
//   the user must write only while no request is in flight (not enforced).
//   Each request walks the three axes in turn; every multiply passes through
//   the shared multiply-accumulate unit as S_MUL (product registered), then
//   S_WB (shift, add and write back). Multiplies per request: reset force 3,
//   load force 0, first half 9, second half 6, impulse 3. The result is
//   registered from S_DONE, and the next request is taken once the sequencer
//   has returned to idle.
//   in_ready is high only while the sequencer is idle.
//   The result sits in an output register; a stalled receiver holds it and
//   the next request runs, but its result waits until the first is taken.
//   Synchronous reset clears state, particle and configuration registers
//   but not the output data or request vector; time step resets to 655.
// ----------------------------------------------------------------------------
module particle_velocity_verlet_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [2:0]     in_op,
  input  pvv_pkg::word_t in_vec_x,
  input  pvv_pkg::word_t in_vec_y,
  input  pvv_pkg::word_t in_vec_z,
  output logic           out_valid,
  input  logic           out_ready,
  output pvv_pkg::word_t out_pos_x,
  output pvv_pkg::word_t out_pos_y,
  output pvv_pkg::word_t out_pos_z,
  output pvv_pkg::word_t out_vel_x,
  output pvv_pkg::word_t out_vel_y,
  output pvv_pkg::word_t out_vel_z,
  output pvv_pkg::word_t out_acc_x,
  output pvv_pkg::word_t out_acc_y,
  output pvv_pkg::word_t out_acc_z,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_wdata
);
  import pvv_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_WB, S_DONE} state_t;

  state_t      state_r, state_nxt;
  logic [31:0] mass_r;
  logic [31:0] inv_mass_r;
  word_t       grav_r [3];
  logic [15:0] dt_r;

  word_t       pos_r [3];
  word_t       vel_r [3];
  word_t       acc_r [3];
  word_t       frc_r [3];
  word_t       hv_r [3];
  logic        half_vld_r;

  logic [2:0]  op_r;
  word_t       vec_r [3];
  logic [1:0]  comp_r;
  logic [1:0]  step_r;
  logic [1:0]  last_step;

  logic        out_valid_r;
  word_t       out_pos_r [3];
  word_t       out_vel_r [3];
  word_t       out_acc_r [3];

  mac_req_t    mac_req;
  word_t       mac_res;

  pvv_mac_unit u_mac (
    .clk (clk),
    .req (mac_req),
    .res (mac_res)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_pos_x = out_pos_r[0];
  assign out_pos_y = out_pos_r[1];
  assign out_pos_z = out_pos_r[2];
  assign out_vel_x = out_vel_r[0];
  assign out_vel_y = out_vel_r[1];
  assign out_vel_z = out_vel_r[2];
  assign out_acc_x = out_acc_r[0];
  assign out_acc_y = out_acc_r[1];
  assign out_acc_z = out_acc_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r     <= '0;
      inv_mass_r <= '0;
      grav_r     <= '{default: '0};
      dt_r       <= TIME_STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MASS:      mass_r     <= cfg_wdata;
        REG_INV_MASS:  inv_mass_r <= cfg_wdata;
        REG_GRAV_X:    grav_r[0]  <= cfg_wdata;
        REG_GRAV_Y:    grav_r[1]  <= cfg_wdata;
        REG_GRAV_Z:    grav_r[2]  <= cfg_wdata;
        REG_TIME_STEP: dt_r       <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (op_r)
      OP_FIRST_HALF:  last_step = 2'd2;
      OP_SECOND_HALF: last_step = 2'd1;
      default:        last_step = 2'd0;
    endcase
  end

  // operand select for the current axis and step
  always_comb begin
    mac_req.a      = frc_r[comp_r];
    mac_req.b      = inv_mass_r;
    mac_req.half   = 1'b0;
    mac_req.addend = '0;
    unique case (op_r)
      OP_RST_FORCE: begin
        mac_req.a = grav_r[comp_r];
        mac_req.b = mass_r;
      end
      OP_FIRST_HALF: begin
        if (step_r == 2'd1) begin
          mac_req.a      = acc_r[comp_r];
          mac_req.b      = {16'd0, dt_r};
          mac_req.half   = 1'b1;
          mac_req.addend = vel_r[comp_r];
        end else if (step_r == 2'd2) begin
          mac_req.a      = hv_r[comp_r];
          mac_req.b      = {16'd0, dt_r};
          mac_req.addend = pos_r[comp_r];
        end
      end
      OP_SECOND_HALF: begin
        if (step_r == 2'd1) begin
          mac_req.a      = acc_r[comp_r];
          mac_req.b      = {16'd0, dt_r};
          mac_req.half   = 1'b1;
          mac_req.addend = half_vld_r ? hv_r[comp_r] : vel_r[comp_r];
        end
      end
      OP_IMPULSE: begin
        mac_req.a      = vec_r[comp_r];
        mac_req.addend = vel_r[comp_r];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_RST_FORCE || in_op == OP_FIRST_HALF ||
              in_op == OP_SECOND_HALF || in_op == OP_IMPULSE) begin
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MUL: state_nxt = S_WB;
      S_WB: begin
        if (step_r == last_step && comp_r == 2'd2) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '{default: '0};
      vel_r       <= '{default: '0};
      acc_r       <= '{default: '0};
      frc_r       <= '{default: '0};
      hv_r        <= '{default: '0};
      half_vld_r  <= 1'b0;
      op_r        <= '0;
      comp_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= in_op;
            vec_r[0] <= in_vec_x;
            vec_r[1] <= in_vec_y;
            vec_r[2] <= in_vec_z;
            comp_r   <= '0;
            step_r   <= '0;
            if (in_op == OP_LOAD_FORCE) begin
              frc_r[0] <= in_vec_x;
              frc_r[1] <= in_vec_y;
              frc_r[2] <= in_vec_z;
            end
          end
        end
        S_MUL: ;
        S_WB: begin
          unique case (op_r)
            OP_RST_FORCE: frc_r[comp_r] <= mac_res;
            OP_FIRST_HALF: begin
              if (step_r == 2'd0) begin
                acc_r[comp_r] <= mac_res;
              end else if (step_r == 2'd1) begin
                hv_r[comp_r] <= mac_res;
              end else begin
                pos_r[comp_r] <= mac_res;
              end
            end
            OP_SECOND_HALF: begin
              if (step_r == 2'd0) begin
                acc_r[comp_r] <= mac_res;
              end else begin
                vel_r[comp_r] <= mac_res;
              end
            end
            OP_IMPULSE: vel_r[comp_r] <= mac_res;
            default: ;
          endcase
          if (step_r == last_step) begin
            step_r <= '0;
            comp_r <= (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
            if (comp_r == 2'd2) begin
              if (op_r == OP_FIRST_HALF) begin
                half_vld_r <= 1'b1;
              end else if (op_r == OP_SECOND_HALF) begin
                half_vld_r <= 1'b0;
              end
            end
          end else begin
            step_r <= step_r + 2'd1;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_pos_r   <= pos_r;
            out_acc_r   <= acc_r;
            if (op_r == OP_FIRST_HALF) begin
              out_vel_r <= hv_r;
            end else begin
              out_vel_r <= vel_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL || state_r == S_WB |-> comp_r != 2'd3)
    else $error("axis counter out of range");

  a_half_set: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && op_r == OP_FIRST_HALF |-> half_vld_r)
    else $error("half-step flag not set after first half");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for particle_velocity_verlet_step
// Drives operation requests through the valid/ready input channel and checks
// every returned position, velocity and acceleration against a local model
// of the integrator state. Covers reset values, each operation, saturation,
// zero and inconsistent mass, register extremes and writes to spare register
// indexes, random idling on both channels and a long receiver hold-off that
// fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb;
  import pvv_pkg::*;

  localparam logic [2:0] UNUSED_OP_5 = 3'd5;
  localparam logic [2:0] UNUSED_OP_6 = 3'd6;
  localparam logic [2:0] UNUSED_OP_7 = 3'd7;
  localparam int         NUM_REG_SLOTS = 8;
  localparam int         HOLD_CYCLES = 300;
  localparam int         CYCLE_LIMIT = 600000;
  localparam longint     SAT_HI = 64'sd2147483647;
  localparam longint     SAT_LO = -64'sd2147483648;
  localparam int         Q_SHIFT = 16;
  localparam int         HALF_SHIFT = 17;

  typedef word_t [8:0] outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_op = 3'd0;
  word_t       in_vec_x = '0;
  word_t       in_vec_y = '0;
  word_t       in_vec_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  word_t       out_pos_x, out_pos_y, out_pos_z;
  word_t       out_vel_x, out_vel_y, out_vel_z;
  word_t       out_acc_x, out_acc_y, out_acc_z;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [31:0] cfg_wdata = '0;

  logic [31:0] cfg_mass = '0;
  logic [31:0] cfg_inv_mass = '0;
  word_t       cfg_grav [3] = '{default: '0};
  logic [15:0] cfg_dt = TIME_STEP_RESET;

  word_t       part_pos [3] = '{default: '0};
  word_t       part_vel [3] = '{default: '0};
  word_t       part_acc [3] = '{default: '0};
  word_t       part_force [3] = '{default: '0};
  word_t       part_half_vel [3] = '{default: '0};
  logic        part_half_ok = 1'b0;

  outcome_t    expected_outcomes [$];
  outcome_t    seen_outcome;
  outcome_t    wanted_outcome;
  string       field_name [9] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                                  "acc_x", "acc_y", "acc_z"};

  int          fail_count = 0;
  int          sent_count = 0;
  int          checked_count = 0;
  int          cycle_count = 0;
  bit          sender_idle_on = 1'b1;
  bit          recv_idle_on = 1'b1;
  int          hold_seq = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          stall_left = 0;

  particle_velocity_verlet_step dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_vec_x  (in_vec_x),
    .in_vec_y  (in_vec_y),
    .in_vec_z  (in_vec_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pos_x (out_pos_x),
    .out_pos_y (out_pos_y),
    .out_pos_z (out_pos_z),
    .out_vel_x (out_vel_x),
    .out_vel_y (out_vel_y),
    .out_vel_z (out_vel_z),
    .out_acc_x (out_acc_x),
    .out_acc_y (out_acc_y),
    .out_acc_z (out_acc_z),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, expected_outcomes.size());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic word_t clamp_word(input longint v);
    longint c;
    c = v;
    if (c > SAT_HI) c = SAT_HI;
    if (c < SAT_LO) c = SAT_LO;
    return c[31:0];
  endfunction

  function automatic word_t scale_floor(input word_t a, input logic [31:0] b, input int sh);
    longint prod;
    prod = longint'(a) * longint'({32'd0, b});
    return clamp_word(prod >>> sh);
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    return clamp_word(longint'(a) + longint'(b));
  endfunction

  function automatic void record_setting(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      REG_MASS:      cfg_mass = data;
      REG_INV_MASS:  cfg_inv_mass = data;
      REG_GRAV_X:    cfg_grav[0] = data;
      REG_GRAV_Y:    cfg_grav[1] = data;
      REG_GRAV_Z:    cfg_grav[2] = data;
      REG_TIME_STEP: cfg_dt = data[15:0];
      default: ;
    endcase
  endfunction

  function automatic outcome_t advance_particle(input logic [2:0] op, input word_t vx,
                                                input word_t vy, input word_t vz);
    word_t    vin [3];
    word_t    a;
    word_t    base;
    bit       show_half;
    outcome_t r;
    int       i;
    vin[0] = vx;
    vin[1] = vy;
    vin[2] = vz;
    show_half = 1'b0;
    case (op)
      OP_RST_FORCE: begin
        for (i = 0; i < 3; i++) part_force[i] = scale_floor(cfg_grav[i], cfg_mass, Q_SHIFT);
      end
      OP_LOAD_FORCE: begin
        for (i = 0; i < 3; i++) part_force[i] = vin[i];
      end
      OP_FIRST_HALF: begin
        for (i = 0; i < 3; i++) begin
          a = scale_floor(part_force[i], cfg_inv_mass, Q_SHIFT);
          part_acc[i] = a;
          part_half_vel[i] = sat_add(part_vel[i], scale_floor(a, {16'd0, cfg_dt}, HALF_SHIFT));
          part_pos[i] = sat_add(part_pos[i],
                                scale_floor(part_half_vel[i], {16'd0, cfg_dt}, Q_SHIFT));
        end
        part_half_ok = 1'b1;
        show_half = 1'b1;
      end
      OP_SECOND_HALF: begin
        for (i = 0; i < 3; i++) begin
          base = part_half_ok ? part_half_vel[i] : part_vel[i];
          a = scale_floor(part_force[i], cfg_inv_mass, Q_SHIFT);
          part_acc[i] = a;
          part_vel[i] = sat_add(base, scale_floor(a, {16'd0, cfg_dt}, HALF_SHIFT));
        end
        part_half_ok = 1'b0;
      end
      OP_IMPULSE: begin
        for (i = 0; i < 3; i++)
          part_vel[i] = sat_add(part_vel[i], scale_floor(vin[i], cfg_inv_mass, Q_SHIFT));
      end
      default: ;
    endcase
    for (i = 0; i < 3; i++) begin
      r[i] = part_pos[i];
      r[3 + i] = show_half ? part_half_vel[i] : part_vel[i];
      r[6 + i] = part_acc[i];
    end
    return r;
  endfunction

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t random_component();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3, 4, 5, 6: return int'($urandom_range(0, 524288)) - 262144;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (recv_idle_on && $urandom_range(0, 99) < 25) begin
      stall_left = idle_length() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_outcome = {out_acc_z, out_acc_y, out_acc_x, out_vel_z, out_vel_y, out_vel_x,
                      out_pos_z, out_pos_y, out_pos_x};
      if (expected_outcomes.size() == 0) begin
        $display("%0t: result with no request pending, pos_x %0d", $time,
                 $signed(out_pos_x));
        fail_count++;
      end else begin
        wanted_outcome = expected_outcomes.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (seen_outcome[k] !== wanted_outcome[k]) begin
            $display("%0t: %s expected %0d actual %0d", $time, field_name[k],
                     $signed(wanted_outcome[k]), $signed(seen_outcome[k]));
            fail_count++;
          end
        end
      end
      checked_count++;
    end
  end

  task automatic send_request(input logic [2:0] op, input word_t vx, input word_t vy,
                              input word_t vz);
    int gap;
    gap = (sender_idle_on && $urandom_range(0, 1)) ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_vec_x <= vx;
    in_vec_y <= vy;
    in_vec_z <= vz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_outcomes.push_back(advance_particle(op, vx, vy, vz));
    sent_count++;
  endtask

  task automatic send_random(input logic [2:0] op);
    send_request(op, random_component(), random_component(), random_component());
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] mass, input logic [31:0] inv,
                                input logic [31:0] gx, input logic [31:0] gy,
                                input logic [31:0] gz, input logic [15:0] dt);
    logic [31:0] vals [NUM_REG_SLOTS];
    logic [31:0] junk;
    int          k;
    drain_requests();
    junk = $urandom;
    vals[0] = mass;
    vals[1] = inv;
    vals[2] = gx;
    vals[3] = gy;
    vals[4] = gz;
    vals[5] = {junk[31:16], dt};
    vals[6] = $urandom;
    vals[7] = $urandom;
    for (k = 0; k < NUM_REG_SLOTS; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= k[2:0];
      cfg_wdata <= vals[k];
      record_setting(k[2:0], vals[k]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic apply_physical_settings();
    logic [31:0] m;
    logic [63:0] inv;
    int          gx, gy, gz;
    m = $urandom_range(32'h8000, 32'h80000);
    inv = 64'h1_0000_0000 / m;
    gx = int'($urandom_range(0, 1310720)) - 655360;
    gy = int'($urandom_range(0, 1310720)) - 655360;
    gz = int'($urandom_range(0, 1310720)) - 655360;
    apply_settings(m, inv[31:0], gx, gy, gz, 16'($urandom_range(1, 6554)));
  endtask

  // mostly force, first half, second half chains; the rest any code
  task automatic run_walk(input int count);
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 99) < 80) begin
        send_random($urandom_range(0, 1) ? OP_RST_FORCE : OP_LOAD_FORCE);
        send_random(OP_FIRST_HALF);
        n += 2;
        if ($urandom_range(0, 3) == 0) begin
          send_random(OP_IMPULSE);
          n++;
        end
        send_random(OP_SECOND_HALF);
        n++;
      end else begin
        send_random(3'($urandom_range(0, 7)));
        n++;
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_request(OP_LOAD_FORCE, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
    send_random(OP_FIRST_HALF);
    send_random(OP_SECOND_HALF);
    send_request(OP_IMPULSE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    send_random(UNUSED_OP_7);
  endtask

  task automatic test_directed_ops();
    apply_settings(32'h0001_0000, 32'h0001_0000, 32'h0, -32'sd642253, 32'h0000_8000,
                   16'd655);
    send_random(OP_RST_FORCE);
    send_random(OP_FIRST_HALF);
    send_random(OP_SECOND_HALF);
    send_random(OP_SECOND_HALF);
    send_request(OP_IMPULSE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    send_request(OP_IMPULSE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(OP_LOAD_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_random(OP_FIRST_HALF);
    send_request(OP_IMPULSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_random(OP_SECOND_HALF);
    send_random(UNUSED_OP_5);
    send_random(UNUSED_OP_6);
    apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'hFFFF_FFFF, 16'hFFFF);
    send_random(OP_RST_FORCE);
    send_random(OP_FIRST_HALF);
    send_random(OP_SECOND_HALF);
    send_request(OP_IMPULSE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    apply_settings(32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 32'hFFFD_0000,
                   32'h0000_0001, 16'd0);
    send_random(OP_RST_FORCE);
    send_random(OP_FIRST_HALF);
    send_random(OP_SECOND_HALF);
  endtask

  task automatic test_physical_walk();
    apply_physical_settings();
    run_walk(100);
    apply_physical_settings();
    run_walk(100);
  endtask

  task automatic test_unidled_walk();
    sender_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    apply_physical_settings();
    run_walk(110);
    sender_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  task automatic test_saturating_walk();
    apply_settings($urandom, $urandom, $urandom, $urandom, $urandom,
                   16'($urandom_range(0, 65535)));
    run_walk(110);
  endtask

  task automatic test_zero_mass_walk();
    apply_settings(32'h0, 32'h0, random_component(), random_component(), random_component(),
                   16'($urandom_range(0, 65535)));
    run_walk(60);
  endtask

  task automatic test_inconsistent_mass_walk();
    apply_settings($urandom, $urandom_range(0, 32'h4_0000), random_component(),
                   random_component(), random_component(), 16'($urandom_range(1, 6554)));
    run_walk(100);
  endtask

  task automatic test_full_block_stall();
    int k;
    apply_physical_settings();
    sender_idle_on = 1'b0;
    hold_seq++;
    for (k = 0; k < 16; k++) begin
      case (k % 4)
        0: send_random(OP_RST_FORCE);
        1: send_random(OP_FIRST_HALF);
        2: send_random(OP_IMPULSE);
        default: send_random(OP_SECOND_HALF);
      endcase
    end
    sender_idle_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_directed_ops();
    test_physical_walk();
    test_unidled_walk();
    test_saturating_walk();
    test_zero_mass_walk();
    test_inconsistent_mass_walk();
    test_full_block_stall();
    drain_requests();
    repeat (40) @(posedge clk);
    $display("Sent %0d requests, checked %0d results: all five operations, unused codes,",
             sent_count, checked_count);
    $display("register extremes, zero and mismatched mass, idling and a full-block stall.");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
